// ===== rtl/core/tfeb_pkg.sv =====
// Shared types and constants for the TCSPC event binner.
// Holds command, result and job encodings, the inter-stage job and result records
// and small helper functions. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package tfeb_pkg;

  typedef enum logic [1:0] {
    CMD_ROLLOVER = 2'd0,
    CMD_MARKER   = 2'd1,
    CMD_PHOTON   = 2'd2,
    CMD_READ     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    RK_ACK         = 3'd0,
    RK_STORED      = 3'd1,
    RK_REJECTED    = 3'd2,
    RK_FRAME_COUNT = 3'd3,
    RK_HIST_VALUE  = 3'd4
  } result_kind_t;

  typedef enum logic [2:0] {
    JOB_ACK,
    JOB_STORE,
    JOB_REJECT,
    JOB_REPORT,
    JOB_READ
  } job_kind_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_NOW,
    F_EXEC,
    F_PHX,
    F_DIVX,
    F_XSET,
    F_PHV,
    F_FRAME,
    F_DIVY,
    F_FEND,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_DISP,
    B_WR,
    B_REP
  } back_state_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_MARKER_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIDIRECTIONAL     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNELS_IN_USE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_HIST_BINS_LOG2    = 3'd5;

  localparam int MARK_PIXEL      = 0;
  localparam int MARK_LINE_START = 1;
  localparam int MARK_LINE_END   = 2;
  localparam int MARK_FRAME      = 3;

  localparam logic [15:0] ROLL_STEP      = 16'hFFFF;
  localparam logic [9:0]  CURSOR_CAP     = 10'd1023;
  localparam logic [3:0]  HIST_LOG2_CAP  = 4'd12;
  localparam logic [2:0]  REPORT_CAP     = 3'd4;

  typedef struct packed {
    job_kind_t   kind;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [3:0]  chan;
    logic [11:0] micro;
    logic [11:0] bin;
    logic        binnable;
    logic        read_ok;
    logic [2:0]  nrep;
  } job_t;

  typedef struct packed {
    result_kind_t kind;
    logic [7:0]   x;
    logic [7:0]   y;
    logic [1:0]   ch;
    logic [15:0]  cnt;
    logic [31:0]  sum;
    logic [31:0]  val;
    logic         last;
  } res_t;

  // Saturating cursor advance; an invalid cursor (minus one) moves to zero.
  function automatic logic [9:0] bump_cursor(input logic vld, input logic [9:0] val);
    logic [9:0] r;
    if (!vld) begin
      r = 10'd0;
    end else if (val == CURSOR_CAP) begin
      r = CURSOR_CAP;
    end else begin
      r = val + 10'd1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tfeb_fifo.sv =====
// Small register queue used between the front and back halves and on the result side.
// Depends on nothing; payload is an opaque vector.
`timescale 1ns / 1ps
`default_nettype none
module tfeb_fifo #(
  parameter int WIDTH      = 8,
  parameter int DEPTH_LOG2 = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]      mem_r [DEPTH];
  logic [DEPTH_LOG2-1:0] wr_ptr_r;
  logic [DEPTH_LOG2-1:0] rd_ptr_r;
  logic [DEPTH_LOG2:0]   count_r;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count_r == (DEPTH_LOG2+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tfeb_front.sv =====
// Front half: configuration registers, 64-bit time base and the frame/line/pixel
// tracker, including both serial dividers. Emits one job per accepted item.
// Depends on tfeb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfeb_front #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_BINS     = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [tfeb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [tfeb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                               take,
  input  wire logic [1:0]                         in_cmd,
  input  wire logic [15:0]                        in_macro_time,
  input  wire logic [3:0]                         in_marker_bits,
  input  wire logic [3:0]                         in_channel,
  input  wire logic [11:0]                        in_micro_time,
  input  wire logic [11:0]                        in_bin_index,
  output logic                                    busy,
  output logic                                    job_valid,
  input  wire logic                               job_full,
  output tfeb_pkg::job_t                          job
);

  // configuration
  logic       pmm_r;
  logic       bidir_r;
  logic [8:0] img_w_r;
  logic [8:0] img_h_r;
  logic [2:0] chans_r;
  logic [3:0] hbl_r;

  // captured item
  tfeb_pkg::cmd_t cmd_r;
  logic [15:0] mt_r;
  logic [3:0]  marks_r;
  logic [3:0]  chan_r;
  logic [11:0] micro_r;
  logic [11:0] bin_r;

  // tracker
  logic [63:0] time_offset_r;
  logic [63:0] line_start_r;
  logic        line_active_r;
  logic        frame_seen_r;
  logic        frame_multi_r;
  logic        cx_vld_r;
  logic [9:0]  cx_r;
  logic        cy_vld_r;
  logic [9:0]  cy_r;
  logic        scan_rev_r;
  logic [63:0] frame_time_r;
  logic [63:0] line_time_r;
  logic        lt_known_r;

  // working registers
  logic [63:0] now_r;
  logic [63:0] delta_r;
  logic [63:0] la_r;
  logic [63:0] dr_r;
  logic [10:0] dq_r;
  logic [3:0]  it_r;
  logic        ph_r;
  logic [10:0] dv_rem_r;
  logic [63:0] dv_quo_r;
  logic [10:0] dv_d_r;
  logic [5:0]  dv_cnt_r;
  tfeb_pkg::job_t job_r;

  tfeb_pkg::front_state_t state_r, state_nxt;

  logic [8:0]  w_raw;
  logic [8:0]  h_raw;
  logic [10:0] use_w;
  logic [10:0] use_h;
  logic [4:0]  nch;
  logic [2:0]  nrep;
  logic [3:0]  nb_log;
  logic [63:0] dur;
  logic [64:0] twice;
  logic        x_geq;
  logic [64:0] x_sub;
  logic        x2_geq;
  logic [11:0] rem2;
  logic        y_geq;
  logic [11:0] y_sub;
  logic        single;
  logic        pix_ok;
  logic        store;
  logic        lt_usable;
  logic [31:0] roll_prod;

  assign w_raw  = (img_w_r == 9'd0) ? 9'd1 : img_w_r;
  assign h_raw  = (img_h_r == 9'd0) ? 9'd1 : img_h_r;
  assign use_w  = (11'(w_raw) > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : 11'(w_raw);
  assign use_h  = (11'(h_raw) > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : 11'(h_raw);
  assign nch    = (5'(chans_r) > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : 5'(chans_r);
  assign nrep   = (nch > 5'(tfeb_pkg::REPORT_CAP)) ? tfeb_pkg::REPORT_CAP : nch[2:0];
  assign nb_log = (hbl_r > tfeb_pkg::HIST_LOG2_CAP) ? tfeb_pkg::HIST_LOG2_CAP : hbl_r;

  assign roll_prod = 32'(mt_r) * 32'(tfeb_pkg::ROLL_STEP);
  assign dur = marks_r[tfeb_pkg::MARK_LINE_START] ? 64'd0 : (now_r - line_start_r);

  assign twice  = {dr_r, 1'b0};
  assign x_geq  = (twice >= {1'b0, line_time_r});
  assign x_sub  = twice - {1'b0, line_time_r};
  assign x2_geq = (dr_r >= la_r);

  assign rem2  = {dv_rem_r, dv_quo_r[63]};
  assign y_geq = (rem2 >= {1'b0, dv_d_r});
  assign y_sub = rem2 - {1'b0, dv_d_r};

  assign lt_usable = lt_known_r && (delta_r < line_time_r);

  assign single = (use_w == 11'd1) && (use_h == 11'd1);
  assign pix_ok = single ||
                  (line_active_r && frame_seen_r && cx_vld_r && ({1'b0, cx_r} < use_w) &&
                   cy_vld_r && ({1'b0, cy_r} < use_h));
  assign store  = pix_ok && ({1'b0, chan_r} < nch);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tfeb_pkg::F_IDLE:  if (take) state_nxt = tfeb_pkg::F_NOW;
      tfeb_pkg::F_NOW:   state_nxt = tfeb_pkg::F_EXEC;
      tfeb_pkg::F_EXEC: begin
        unique case (cmd_r)
          tfeb_pkg::CMD_MARKER: begin
            state_nxt = marks_r[tfeb_pkg::MARK_FRAME] ? tfeb_pkg::F_FRAME : tfeb_pkg::F_PUSH;
          end
          tfeb_pkg::CMD_PHOTON: begin
            state_nxt = (!pmm_r && use_w > 11'd1) ? tfeb_pkg::F_PHX : tfeb_pkg::F_PHV;
          end
          default: state_nxt = tfeb_pkg::F_PUSH;
        endcase
      end
      tfeb_pkg::F_PHX:   state_nxt = lt_usable ? tfeb_pkg::F_DIVX : tfeb_pkg::F_PHV;
      tfeb_pkg::F_DIVX: begin
        if ((ph_r || !use_w[it_r]) && it_r == 4'd0) state_nxt = tfeb_pkg::F_XSET;
      end
      tfeb_pkg::F_XSET:  state_nxt = tfeb_pkg::F_PHV;
      tfeb_pkg::F_PHV:   state_nxt = tfeb_pkg::F_PUSH;
      tfeb_pkg::F_FRAME: begin
        state_nxt = (frame_multi_r && cy_vld_r) ? tfeb_pkg::F_DIVY : tfeb_pkg::F_FEND;
      end
      tfeb_pkg::F_DIVY:  if (dv_cnt_r == 6'd63) state_nxt = tfeb_pkg::F_FEND;
      tfeb_pkg::F_FEND:  state_nxt = tfeb_pkg::F_PUSH;
      tfeb_pkg::F_PUSH:  if (!job_full) state_nxt = tfeb_pkg::F_IDLE;
      default:           state_nxt = tfeb_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state_r != tfeb_pkg::F_IDLE);
    job_valid = (state_r == tfeb_pkg::F_PUSH);
    job       = job_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfeb_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmm_r   <= 1'b1;
      bidir_r <= 1'b0;
      img_w_r <= 9'd256;
      img_h_r <= 9'd256;
      chans_r <= 3'd1;
      hbl_r   <= 4'd12;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tfeb_pkg::CFG_PIXEL_MARKER_MODE: pmm_r   <= cfg_wdata[0];
        tfeb_pkg::CFG_BIDIRECTIONAL:     bidir_r <= cfg_wdata[0];
        tfeb_pkg::CFG_IMAGE_WIDTH:       img_w_r <= cfg_wdata;
        tfeb_pkg::CFG_IMAGE_HEIGHT:      img_h_r <= cfg_wdata;
        tfeb_pkg::CFG_CHANNELS_IN_USE:   chans_r <= cfg_wdata[2:0];
        tfeb_pkg::CFG_HIST_BINS_LOG2:    hbl_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state_r)
      tfeb_pkg::F_IDLE: begin
        if (take) begin
          cmd_r   <= tfeb_pkg::cmd_t'(in_cmd);
          mt_r    <= in_macro_time;
          marks_r <= in_marker_bits;
          chan_r  <= in_channel;
          micro_r <= in_micro_time;
          bin_r   <= in_bin_index;
        end
      end
      tfeb_pkg::F_NOW: begin
        now_r <= time_offset_r + 64'(mt_r);
        job_r <= '0;
      end
      tfeb_pkg::F_EXEC: begin
        delta_r <= now_r - line_start_r;
        if (cmd_r == tfeb_pkg::CMD_READ) begin
          job_r.kind    <= tfeb_pkg::JOB_READ;
          job_r.chan    <= chan_r;
          job_r.bin     <= bin_r;
          job_r.read_ok <= (5'(chan_r) < 5'(MAX_CHANNELS)) && (13'(bin_r) < 13'(MAX_BINS));
        end else begin
          job_r.kind <= tfeb_pkg::JOB_ACK;
        end
      end
      tfeb_pkg::F_PHX: begin
        la_r     <= line_time_r - delta_r;
        dr_r     <= 64'd0;
        dq_r     <= 11'd0;
        it_r     <= 4'd10;
        ph_r     <= 1'b0;
      end
      tfeb_pkg::F_DIVX: begin
        if (!ph_r) begin
          dr_r <= x_geq ? x_sub[63:0] : twice[63:0];
          dq_r <= {dq_r[9:0], x_geq};
          if (use_w[it_r]) begin
            ph_r <= 1'b1;
          end else if (it_r != 4'd0) begin
            it_r <= it_r - 4'd1;
          end
        end else begin
          dr_r <= x2_geq ? (dr_r - la_r) : (dr_r + delta_r);
          dq_r <= dq_r + 11'(x2_geq);
          ph_r <= 1'b0;
          if (it_r != 4'd0) begin
            it_r <= it_r - 4'd1;
          end
        end
      end
      tfeb_pkg::F_PHV: begin
        if (store) begin
          job_r.kind     <= tfeb_pkg::JOB_STORE;
          job_r.x        <= single ? 10'd0 : cx_r;
          job_r.y        <= single ? 10'd0 : cy_r;
          job_r.chan     <= chan_r;
          job_r.micro    <= micro_r;
          job_r.binnable <= ((micro_r >> nb_log) == 12'd0) && (13'(micro_r) < 13'(MAX_BINS));
        end else begin
          job_r.kind <= tfeb_pkg::JOB_REJECT;
        end
      end
      tfeb_pkg::F_FRAME: begin
        dv_rem_r <= 11'd0;
        dv_quo_r <= frame_time_r;
        dv_d_r   <= 11'(cy_r) + 11'd1;
        dv_cnt_r <= 6'd0;
      end
      tfeb_pkg::F_DIVY: begin
        dv_rem_r <= y_geq ? y_sub[10:0] : rem2[10:0];
        dv_quo_r <= {dv_quo_r[62:0], y_geq};
        dv_cnt_r <= dv_cnt_r + 6'd1;
      end
      tfeb_pkg::F_FEND: begin
        if (frame_seen_r) begin
          job_r.kind <= tfeb_pkg::JOB_REPORT;
          job_r.nrep <= nrep;
        end else begin
          job_r.kind <= tfeb_pkg::JOB_ACK;
        end
      end
      default: ;
    endcase
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_offset_r <= 64'd0;
      line_start_r  <= 64'd0;
      line_active_r <= 1'b0;
      frame_seen_r  <= 1'b0;
      frame_multi_r <= 1'b0;
      cx_vld_r      <= 1'b0;
      cx_r          <= 10'd0;
      cy_vld_r      <= 1'b0;
      cy_r          <= 10'd0;
      scan_rev_r    <= 1'b0;
      frame_time_r  <= 64'd0;
      line_time_r   <= 64'd0;
      lt_known_r    <= 1'b0;
    end else begin
      unique case (state_r)
        tfeb_pkg::F_EXEC: begin
          if (cmd_r == tfeb_pkg::CMD_ROLLOVER) begin
            time_offset_r <= time_offset_r + 64'(roll_prod);
          end else if (cmd_r == tfeb_pkg::CMD_MARKER && frame_seen_r) begin
            if (marks_r[tfeb_pkg::MARK_PIXEL] && pmm_r) begin
              cx_r     <= tfeb_pkg::bump_cursor(cx_vld_r, cx_r);
              cx_vld_r <= 1'b1;
            end
            if (marks_r[tfeb_pkg::MARK_LINE_START]) begin
              line_start_r  <= now_r;
              line_active_r <= 1'b1;
              cx_r          <= 10'd0;
              cx_vld_r      <= 1'b1;
              if (bidir_r) begin
                scan_rev_r <= !scan_rev_r;
              end
              cy_r     <= tfeb_pkg::bump_cursor(cy_vld_r, cy_r);
              cy_vld_r <= 1'b1;
            end
            if (marks_r[tfeb_pkg::MARK_LINE_END]) begin
              frame_time_r <= frame_time_r + dur;
              if (!lt_known_r) begin
                line_time_r <= dur;
                lt_known_r  <= 1'b1;
              end
              line_active_r <= 1'b0;
            end
          end
        end
        tfeb_pkg::F_PHX: begin
          if (!lt_usable) begin
            cx_vld_r <= 1'b0;
          end
        end
        tfeb_pkg::F_XSET: begin
          cx_r     <= scan_rev_r ? 10'(use_w - 11'd1 - dq_r) : dq_r[9:0];
          cx_vld_r <= 1'b1;
        end
        tfeb_pkg::F_DIVY: begin
          if (dv_cnt_r == 6'd63) begin
            line_time_r <= {dv_quo_r[62:0], y_geq};
            lt_known_r  <= 1'b1;
          end
        end
        tfeb_pkg::F_FEND: begin
          frame_multi_r <= frame_seen_r;
          frame_seen_r  <= 1'b1;
          cx_vld_r      <= 1'b0;
          cy_vld_r      <= 1'b0;
          scan_rev_r    <= 1'b0;
          frame_time_r  <= 64'd0;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tfeb_back.sv =====
// Back half: pixel and decay histogram memories with their clearing pass, the
// per-channel frame counters and result generation. Depends on tfeb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfeb_back #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_BINS     = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_avail,
  input  wire tfeb_pkg::job_t job_in,
  output logic                job_pop,
  output logic                res_push,
  output tfeb_pkg::res_t      res,
  input  wire logic           res_full,
  output logic                clearing
);

  localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int BW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int PAW = XW + YW;
  localparam int DAW = CW + BW;
  localparam int CLW = (PAW > DAW) ? PAW : DAW;

  logic [47:0] pix_mem [2**PAW];
  logic [31:0] dec_mem [2**DAW];
  logic [47:0] pix_rd_r;
  logic [31:0] dec_rd_r;
  logic [31:0] fc_r [MAX_CHANNELS];

  tfeb_pkg::back_state_t state_r, state_nxt;
  tfeb_pkg::job_t jb_r;
  logic [CLW-1:0] clr_r;
  logic [2:0]     idx_r;

  logic [PAW-1:0] pa;
  logic [DAW-1:0] da;
  logic [11:0]    dbin;
  logic [15:0]    new_cnt;
  logic [32:0]    sum33;
  logic [31:0]    new_sum;
  logic [CW-1:0]  fsel;
  logic [31:0]    fc_cur;
  logic           rep_last;
  logic           emit;
  logic           pix_we;
  logic           dec_we;
  logic [31:0]    dec_wd;

  assign dbin    = (jb_r.kind == tfeb_pkg::JOB_READ) ? jb_r.bin : jb_r.micro;
  assign pa      = {jb_r.y[YW-1:0], jb_r.x[XW-1:0]};
  assign da      = {jb_r.chan[CW-1:0], dbin[BW-1:0]};
  assign new_cnt = pix_rd_r[47:32] + 16'd1;
  assign sum33   = {1'b0, pix_rd_r[31:0]} + 33'(jb_r.micro);
  assign new_sum = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
  assign fsel    = (state_r == tfeb_pkg::B_REP) ? CW'(idx_r) : jb_r.chan[CW-1:0];
  assign fc_cur  = fc_r[fsel];
  assign rep_last = (jb_r.nrep == 3'd0) || (idx_r == jb_r.nrep - 3'd1);
  assign clearing = (state_r == tfeb_pkg::B_CLEAR);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tfeb_pkg::B_CLEAR: if (clr_r == {CLW{1'b1}}) state_nxt = tfeb_pkg::B_IDLE;
      tfeb_pkg::B_IDLE:  if (job_avail) state_nxt = tfeb_pkg::B_DISP;
      tfeb_pkg::B_DISP: begin
        unique case (jb_r.kind)
          tfeb_pkg::JOB_STORE,
          tfeb_pkg::JOB_READ:   state_nxt = tfeb_pkg::B_WR;
          tfeb_pkg::JOB_REPORT: state_nxt = tfeb_pkg::B_REP;
          default:              if (!res_full) state_nxt = tfeb_pkg::B_IDLE;
        endcase
      end
      tfeb_pkg::B_WR:  if (!res_full) state_nxt = tfeb_pkg::B_IDLE;
      tfeb_pkg::B_REP: if (!res_full && rep_last) state_nxt = tfeb_pkg::B_IDLE;
      default:         state_nxt = tfeb_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_pop = (state_r == tfeb_pkg::B_IDLE) && job_avail;
    emit    = 1'b0;
    pix_we  = 1'b0;
    dec_we  = 1'b0;
    dec_wd  = 32'd0;
    res     = '0;
    res.last = 1'b1;
    unique case (state_r)
      tfeb_pkg::B_CLEAR: begin
        pix_we = 1'b1;
        dec_we = 1'b1;
      end
      tfeb_pkg::B_DISP: begin
        if (jb_r.kind == tfeb_pkg::JOB_ACK || jb_r.kind == tfeb_pkg::JOB_REJECT) begin
          emit     = !res_full;
          res.kind = (jb_r.kind == tfeb_pkg::JOB_REJECT) ? tfeb_pkg::RK_REJECTED
                                                          : tfeb_pkg::RK_ACK;
        end
      end
      tfeb_pkg::B_WR: begin
        emit = !res_full;
        if (jb_r.kind == tfeb_pkg::JOB_STORE) begin
          pix_we   = emit;
          dec_we   = emit && jb_r.binnable;
          dec_wd   = dec_rd_r + 32'd1;
          res.kind = tfeb_pkg::RK_STORED;
          res.x    = jb_r.x[7:0];
          res.y    = jb_r.y[7:0];
          res.ch   = jb_r.chan[1:0];
          res.cnt  = new_cnt;
          res.sum  = new_sum;
        end else begin
          dec_we   = emit && jb_r.read_ok;
          res.kind = tfeb_pkg::RK_HIST_VALUE;
          res.ch   = jb_r.chan[1:0];
          res.val  = jb_r.read_ok ? dec_rd_r : 32'd0;
        end
      end
      tfeb_pkg::B_REP: begin
        emit = !res_full;
        if (jb_r.nrep != 3'd0) begin
          res.kind = tfeb_pkg::RK_FRAME_COUNT;
          res.ch   = idx_r[1:0];
          res.val  = fc_cur;
          res.last = rep_last;
        end
      end
      default: ;
    endcase
    res_push = emit;
  end

  // memories: registered read, single write port each
  always_ff @(posedge clk) begin
    pix_rd_r <= pix_mem[pa];
    dec_rd_r <= dec_mem[da];
    if (pix_we) begin
      if (clearing) begin
        pix_mem[clr_r[PAW-1:0]] <= 48'd0;
      end else begin
        pix_mem[pa] <= {new_cnt, new_sum};
      end
    end
    if (dec_we) begin
      if (clearing) begin
        dec_mem[clr_r[DAW-1:0]] <= 32'd0;
      end else begin
        dec_mem[da] <= dec_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      jb_r <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfeb_pkg::B_CLEAR;
      clr_r   <= '0;
      idx_r   <= 3'd0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        fc_r[i] <= 32'd0;
      end
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == tfeb_pkg::B_WR && emit && jb_r.kind == tfeb_pkg::JOB_STORE) begin
        fc_r[fsel] <= fc_cur + 32'd1;
      end
      if (state_r == tfeb_pkg::B_REP && emit) begin
        if (rep_last) begin
          idx_r <= 3'd0;
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            fc_r[i] <= 32'd0;
          end
        end else begin
          idx_r <= idx_r + 3'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tcspc_flim_event_binner_unit.sv =====
// TCSPC event binner, top level. Instantiates the front tracker, the job queue,
// the memory back end and the result queue. Depends on tfeb_pkg and the tfeb_* modules.
//
// Usage: after reset the block sweeps both memories to zero, one address a cycle,
// over 2^max(log2(MAX_WIDTH)+log2(MAX_HEIGHT), log2(MAX_CHANNELS)+log2(MAX_BINS))
// addresses (65536 with the default sizes). in_full stays high for that whole time,
// while configuration writes are taken as ever. The front takes one item at a time.
// From one input transfer on, the front steps through these states before the next:
// - a rollover, a read command or a plain marker: capture, time stamp, execute, push;
// - a photon in pixel-marker mode, or in a one-column image, also places the pixel;
// - a photon in line-timing mode also checks for a usable line duration. If there is
//   one, the serial column division works out eleven quotient bits, with one more
//   step on every set bit of the image width, and then sets the column;
// - a frame marker also closes the frame. From the third one on, when a line started
//   in the last frame, a 64-step serial divider first works out the line duration.
// Each finished item goes to a four-entry job queue. The back end takes a photon or
// a read job, reads the memories, then writes back and hands over the result; an
// acknowledge or a rejection it takes and hands over with no memory access. On a
// frame report it hands over one result per reported channel, or a single one when
// no channel is in use. Each of these is held up only while the result queue is
// full, so front and back overlap and the front sets the pace. A full job queue holds
// the front in its push state. Results wait in a four-entry queue until popped.
// Configuration is meant to be written while idle.
`timescale 1ns / 1ps
`default_nettype none
module tcspc_flim_event_binner_unit #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_BINS     = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [tfeb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tfeb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire logic [1:0]                       in_cmd,
  input  wire logic [15:0]                      in_macro_time,
  input  wire logic [3:0]                       in_marker_bits,
  input  wire logic [3:0]                       in_channel,
  input  wire logic [11:0]                      in_micro_time,
  input  wire logic [11:0]                      in_bin_index,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output logic [2:0]                            out_result_kind,
  output logic [7:0]                            out_pixel_x,
  output logic [7:0]                            out_pixel_y,
  output logic [1:0]                            out_out_channel,
  output logic [15:0]                           out_pixel_count,
  output logic [31:0]                           out_pixel_time_sum,
  output logic [31:0]                           out_value,
  output logic                                  out_last
);

  localparam int JOB_W = $bits(tfeb_pkg::job_t);
  localparam int RES_W = $bits(tfeb_pkg::res_t);

  logic           front_busy;
  logic           clearing;
  logic           take;
  logic           job_valid;
  logic           job_full;
  logic           job_empty;
  logic           job_pop;
  tfeb_pkg::job_t front_job;
  tfeb_pkg::job_t queued_job;
  logic           res_push;
  logic           res_full;
  tfeb_pkg::res_t back_res;
  tfeb_pkg::res_t head_res;

  // The front only takes a transfer once the memory sweep is over.
  assign in_full = front_busy || clearing;
  assign take    = in_push && !in_full;

  tfeb_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_BINS    (MAX_BINS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .take          (take),
    .in_cmd        (in_cmd),
    .in_macro_time (in_macro_time),
    .in_marker_bits(in_marker_bits),
    .in_channel    (in_channel),
    .in_micro_time (in_micro_time),
    .in_bin_index  (in_bin_index),
    .busy          (front_busy),
    .job_valid     (job_valid),
    .job_full      (job_full),
    .job           (front_job)
  );

  tfeb_fifo #(
    .WIDTH     (JOB_W),
    .DEPTH_LOG2(2)
  ) u_job_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_valid),
    .wr_data(front_job),
    .full   (job_full),
    .pop    (job_pop),
    .rd_data(queued_job),
    .empty  (job_empty)
  );

  tfeb_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_BINS    (MAX_BINS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_avail(!job_empty),
    .job_in   (queued_job),
    .job_pop  (job_pop),
    .res_push (res_push),
    .res      (back_res),
    .res_full (res_full),
    .clearing (clearing)
  );

  tfeb_fifo #(
    .WIDTH     (RES_W),
    .DEPTH_LOG2(2)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .wr_data(back_res),
    .full   (res_full),
    .pop    (out_pop),
    .rd_data(head_res),
    .empty  (out_empty)
  );

  assign out_result_kind    = head_res.kind;
  assign out_pixel_x        = head_res.x;
  assign out_pixel_y        = head_res.y;
  assign out_out_channel    = head_res.ch;
  assign out_pixel_count    = head_res.cnt;
  assign out_pixel_time_sum = head_res.sum;
  assign out_value          = head_res.val;
  assign out_last           = head_res.last;

`ifndef ASSERT_OFF
  a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> in_full)
    else $error("input transfer possible during memory sweep");

  a_job_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job_full |=> $stable(front_busy))
    else $error("front left a stalled job push");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_no_pop_while_sweeping: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !job_pop && !res_push)
    else $error("back end active during memory sweep");
`endif

endmodule
`default_nettype wire

// ===== bench/event_binner_checker.sv =====
// Checker for the TCSPC event binner: watches the input, result and configuration ports,
// predicts every result from its own model of the block and compares them in order.
// Depends on tfeb_pkg for the command and result encodings.
`timescale 1ns / 1ps
module event_binner_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [tfeb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tfeb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_push,
  input  logic                             in_full,
  input  logic [1:0]                       in_cmd,
  input  logic [15:0]                      in_macro_time,
  input  logic [3:0]                       in_marker_bits,
  input  logic [3:0]                       in_channel,
  input  logic [11:0]                      in_micro_time,
  input  logic [11:0]                      in_bin_index,
  input  logic                             out_empty,
  input  logic                             out_pop,
  input  logic [2:0]                       out_result_kind,
  input  logic [7:0]                       out_pixel_x,
  input  logic [7:0]                       out_pixel_y,
  input  logic [1:0]                       out_out_channel,
  input  logic [15:0]                      out_pixel_count,
  input  logic [31:0]                      out_pixel_time_sum,
  input  logic [31:0]                      out_value,
  input  logic                             out_last,
  output int                               mismatches,
  output int                               outstanding
);
  import tfeb_pkg::*;

  localparam longint FRAME_LIMIT = 64'h7FFF_FFFF;

  // Configuration copy.
  bit       marker_mode = 1'b1;
  bit       bidir       = 1'b0;
  bit [8:0] width_reg   = 9'd256;
  bit [8:0] height_reg  = 9'd256;
  bit [2:0] chans_reg   = 3'd1;
  bit [3:0] bins_reg    = 4'd12;

  // Tracker state.
  bit [63:0] time_base, line_begin, frame_span, line_span;
  bit        in_line, reversed, span_known;
  longint    frame_no = -1;
  int        col = -1, row = -1;

  bit [15:0] photon_count [0:65535];
  bit [31:0] arrival_sum  [0:65535];
  bit [31:0] decay_hist   [0:16383];
  bit [31:0] frame_total  [0:3];

  res_t expected_results[$];
  int   errors = 0;

  function automatic int step_cursor(input int c);
    return (c < 1023) ? c + 1 : 1023;
  endfunction

  task automatic bin_event(input logic [1:0] cmd, input logic [15:0] mt,
                           input logic [3:0] mk, input logic [3:0] ch,
                           input logic [11:0] micro, input logic [11:0] bin);
    res_t       r [0:4];
    int         n, w, h, nch, p, xq, nlog;
    bit [63:0]  now, dur, delta;
    bit [127:0] prod;
    bit         valid;
    bit [31:0]  s;
    n   = 0;
    w   = (width_reg == 0) ? 1 : ((width_reg > 256) ? 256 : width_reg);
    h   = (height_reg == 0) ? 1 : ((height_reg > 256) ? 256 : height_reg);
    nch = (chans_reg > 4) ? 4 : chans_reg;
    now = time_base + {48'd0, mt};
    for (int i = 0; i < 5; i++) r[i] = '0;
    case (cmd)
      CMD_ROLLOVER: begin
        time_base = time_base + 64'hFFFF * {48'd0, mt};
        n = 1;
      end
      CMD_MARKER: begin
        if (frame_no >= 0) begin
          if (mk[MARK_PIXEL] && marker_mode) col = step_cursor(col);
          if (mk[MARK_LINE_START]) begin
            line_begin = now;
            in_line    = 1'b1;
            col        = 0;
            if (bidir) reversed = !reversed;
            row = step_cursor(row);
          end
          if (mk[MARK_LINE_END]) begin
            dur        = now - line_begin;
            frame_span = frame_span + dur;
            if (!span_known) begin
              line_span  = dur;
              span_known = 1'b1;
            end
            in_line = 1'b0;
          end
        end
        if (mk[MARK_FRAME]) begin
          if (frame_no > 0 && row >= 0) begin
            line_span  = frame_span / (row + 1);
            span_known = 1'b1;
          end
          if (frame_no >= 0) begin
            for (int c = 0; c < nch; c++) begin
              r[n].kind = RK_FRAME_COUNT;
              r[n].ch   = c[1:0];
              r[n].val  = frame_total[c];
              n++;
            end
            for (int c = 0; c < 4; c++) frame_total[c] = 0;
          end
          if (frame_no < FRAME_LIMIT) frame_no++;
          col        = -1;
          row        = -1;
          reversed   = 1'b0;
          frame_span = 0;
        end
        if (n == 0) n = 1;
      end
      CMD_PHOTON: begin
        if (!marker_mode && w > 1) begin
          delta = now - line_begin;
          if (span_known && line_span != 0 && delta < line_span) begin
            // Column is the exact floor of delta * width / line duration.
            prod = {64'd0, delta} * 128'(w);
            xq   = int'(prod / {64'd0, line_span});
            col  = reversed ? w - 1 - xq : xq;
          end else begin
            col = -1;
          end
        end
        if (w == 1 && h == 1) begin
          valid = 1'b1;
          xq    = 0;
          p     = 0;
        end else begin
          valid = in_line && frame_no >= 0 && col >= 0 && col < w && row >= 0 && row < h;
          p     = row * 256 + col;
          xq    = col;
        end
        if (valid && ch < nch) begin
          photon_count[p] = photon_count[p] + 16'd1;
          s = arrival_sum[p];
          s = (s > 32'hFFFF_FFFF - micro) ? 32'hFFFF_FFFF : s + micro;
          arrival_sum[p] = s;
          nlog = (bins_reg > 12) ? 12 : bins_reg;
          if (micro < (1 << nlog)) decay_hist[ch * 4096 + micro]++;
          frame_total[ch]++;
          r[0].kind = RK_STORED;
          r[0].x    = xq[7:0];
          r[0].y    = (p / 256);
          r[0].ch   = ch[1:0];
          r[0].cnt  = photon_count[p];
          r[0].sum  = s;
        end else begin
          r[0].kind = RK_REJECTED;
        end
        n = 1;
      end
      default: begin
        r[0].kind = RK_HIST_VALUE;
        r[0].ch   = ch[1:0];
        if (ch < 4) begin
          r[0].val = decay_hist[ch * 4096 + bin];
          decay_hist[ch * 4096 + bin] = 0;
        end
        n = 1;
      end
    endcase
    r[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.insert(expected_results.size(), r[i]);
  endtask

  always @(posedge clk) begin
    res_t e;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PIXEL_MARKER_MODE: marker_mode = cfg_wdata[0];
        CFG_BIDIRECTIONAL:     bidir       = cfg_wdata[0];
        CFG_IMAGE_WIDTH:       width_reg   = cfg_wdata[8:0];
        CFG_IMAGE_HEIGHT:      height_reg  = cfg_wdata[8:0];
        CFG_CHANNELS_IN_USE:   chans_reg   = cfg_wdata[2:0];
        CFG_HIST_BINS_LOG2:    bins_reg    = cfg_wdata[3:0];
        default: ;
      endcase
    end
    if (rst_n && in_push && !in_full)
      bin_event(in_cmd, in_macro_time, in_marker_bits, in_channel, in_micro_time,
                in_bin_index);
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result transfer with nothing expected: kind %0d",
                                   out_result_kind);
      end else begin
        e = expected_results.pop_front();
        if (out_result_kind != e.kind || out_pixel_x != e.x || out_pixel_y != e.y ||
            out_out_channel != e.ch || out_pixel_count != e.cnt ||
            out_pixel_time_sum != e.sum || out_value != e.val || out_last != e.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch expected kind %0d x %0d y %0d ch %0d cnt %0d sum %h val %h last %0d",
                     e.kind, e.x, e.y, e.ch, e.cnt, e.sum, e.val, e.last);
            $display("         actual   kind %0d x %0d y %0d ch %0d cnt %0d sum %h val %h last %0d",
                     out_result_kind, out_pixel_x, out_pixel_y, out_out_channel,
                     out_pixel_count, out_pixel_time_sum, out_value, out_last);
          end
        end
      end
    end
    mismatches  <= errors;
    outstanding <= expected_results.size();
  end

endmodule

// ===== bench/tb.sv =====
// Top of the event binner testbench: clock, reset, stimulus and the final verdict.
// Depends on tfeb_pkg, tcspc_flim_event_binner_unit and event_binner_checker.
`timescale 1ns / 1ps
module tb;
  import tfeb_pkg::*;

  // The clearing sweep after reset alone covers 65536 addresses; the rest of the run is
  // far shorter, so this limit leaves several times the slowest correct run.
  localparam int CYCLE_LIMIT = 700000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [8:0]  cfg_wdata = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_cmd = '0;
  logic [15:0] in_macro_time = '0;
  logic [3:0]  in_marker_bits = '0;
  logic [3:0]  in_channel = '0;
  logic [11:0] in_micro_time = '0;
  logic [11:0] in_bin_index = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_result_kind;
  logic [7:0]  out_pixel_x, out_pixel_y;
  logic [1:0]  out_out_channel;
  logic [15:0] out_pixel_count;
  logic [31:0] out_pixel_time_sum, out_value;
  logic        out_last;

  int mismatches, outstanding;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  // Running macro-time stamp for well-formed scans; a rollover is sent when it nears the top.
  int stamp = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  tcspc_flim_event_binner_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_push(in_push), .in_full(in_full), .in_cmd(in_cmd), .in_macro_time(in_macro_time),
    .in_marker_bits(in_marker_bits), .in_channel(in_channel),
    .in_micro_time(in_micro_time), .in_bin_index(in_bin_index),
    .out_empty(out_empty), .out_pop(out_pop), .out_result_kind(out_result_kind),
    .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_out_channel(out_out_channel), .out_pixel_count(out_pixel_count),
    .out_pixel_time_sum(out_pixel_time_sum), .out_value(out_value), .out_last(out_last)
  );

  event_binner_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_push(in_push), .in_full(in_full), .in_cmd(in_cmd), .in_macro_time(in_macro_time),
    .in_marker_bits(in_marker_bits), .in_channel(in_channel),
    .in_micro_time(in_micro_time), .in_bin_index(in_bin_index),
    .out_empty(out_empty), .out_pop(out_pop), .out_result_kind(out_result_kind),
    .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_out_channel(out_out_channel), .out_pixel_count(out_pixel_count),
    .out_pixel_time_sum(out_pixel_time_sum), .out_value(out_value), .out_last(out_last),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // The receiver stalls at random; the stall rate is set per phase.
  always @(posedge clk) out_pop <= rst_n && ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one item, after a random idle gap, and holds it until the transfer happens.
  // The push stays high into the next item when there is no gap, so it is never
  // lowered and raised in the same step.
  task automatic send(input logic [1:0] cmd, input logic [15:0] mt, input logic [3:0] mk,
                      input logic [3:0] ch, input logic [11:0] mi, input logic [11:0] bi);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_cmd         <= cmd;
    in_macro_time  <= mt;
    in_marker_bits <= mk;
    in_channel     <= ch;
    in_micro_time  <= mi;
    in_bin_index   <= bi;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Sends an item stamped with the running time, so that scans look like real ones.
  task automatic timed(input logic [1:0] cmd, input logic [3:0] mk, input logic [3:0] ch,
                       input logic [11:0] mi, input logic [11:0] bi);
    if (stamp > 60000) begin
      send(CMD_ROLLOVER, 16'd1, 4'($urandom), 4'($urandom), 12'($urandom), 12'($urandom));
      stamp = 0;
    end
    stamp += $urandom_range(1, 40);
    send(cmd, stamp[15:0], mk, ch, mi, bi);
  endtask

  task automatic photon();
    int          pick;
    logic [11:0] micro;
    logic [3:0]  ch;
    pick  = $urandom_range(99);
    micro = (pick < 10) ? 12'hFFF : (pick < 20) ? 12'd0 :
            (pick < 50) ? 12'($urandom_range(7)) : 12'($urandom);
    ch    = ($urandom_range(99) < 85) ? 4'($urandom_range(3)) : 4'($urandom);
    timed(CMD_PHOTON, 4'($urandom), ch, micro, 12'($urandom));
  endtask

  // One frame of well-formed scan lines with random content and a little noise. The
  // frame counts of the previous frame are reported by the opening frame marker.
  task automatic scan_frame(input int lines, input int events);
    int pick;
    timed(CMD_MARKER, ($urandom_range(3) == 0) ? 4'($urandom) | 4'b1000 : 4'b1000,
          4'($urandom), 12'($urandom), 12'($urandom));
    for (int l = 0; l < lines; l++) begin
      timed(CMD_MARKER, 4'b0010 | 4'($urandom_range(1)), 4'($urandom), 12'($urandom),
            12'($urandom));
      for (int e = 0; e < events; e++) begin
        pick = $urandom_range(99);
        if (pick < 60) photon();
        else if (pick < 80)
          timed(CMD_MARKER, 4'b0001, 4'($urandom), 12'($urandom), 12'($urandom));
        else if (pick < 90)
          timed(CMD_READ, 4'($urandom), 4'($urandom_range(4)), 12'($urandom),
                ($urandom_range(1) == 0) ? 12'($urandom_range(7)) : 12'($urandom));
        else
          send(2'($urandom), 16'($urandom), 4'($urandom), 4'($urandom), 12'($urandom),
               12'($urandom));
      end
      timed(CMD_MARKER, 4'b0100, 4'($urandom), 12'($urandom), 12'($urandom));
    end
  endtask

  // Stops offering items until every expected result has come, then lets the block settle.
  task automatic drain(input int settle);
    in_push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Writes all six registers on consecutive cycles; only written while the block is idle.
  task automatic apply_cfg(input int pm, input int bd, input int w, input int h,
                           input int nch, input int nbl);
    int vals [0:5];
    vals = '{pm, bd, w, h, nch, nbl};
    for (int i = 0; i < 6; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= 9'(vals[i]);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic phase(input int pm, input int bd, input int w, input int h,
                       input int nch, input int nbl, input int idle, input int stall,
                       input bit hold_midway);
    drain(100);
    apply_cfg(pm, bd, w, h, nch, nbl);
    idle_pct  = idle;
    stall_pct = stall;
    for (int f = 0; f < 2; f++) begin
      scan_frame($urandom_range(1, 3), $urandom_range(2, 5));
      // The sender waits here once until the block has handed over everything.
      if (hold_midway && f == 0) drain(0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset configuration: one channel, full size, marker mode.
    send(CMD_MARKER, 16'd5, 4'b0111, 4'd0, 12'd0, 12'd0);       // markers before any frame
    send(CMD_PHOTON, 16'd6, 4'd0, 4'd0, 12'd1, 12'd0);          // photon before any frame
    send(CMD_READ, 16'd0, 4'd0, 4'd0, 12'd0, 12'd0);
    send(CMD_ROLLOVER, 16'hFFFF, 4'hF, 4'hF, 12'hFFF, 12'hFFF);
    send(CMD_MARKER, 16'd10, 4'b1111, 4'd0, 12'd0, 12'd0);      // first frame: ack only
    send(CMD_MARKER, 16'd20, 4'b0010, 4'd0, 12'd0, 12'd0);
    send(CMD_PHOTON, 16'd21, 4'd0, 4'd0, 12'hFFF, 12'd0);
    send(CMD_MARKER, 16'd22, 4'b0001, 4'd0, 12'd0, 12'd0);
    send(CMD_PHOTON, 16'd23, 4'd0, 4'd0, 12'd0, 12'd0);
    send(CMD_PHOTON, 16'd24, 4'd0, 4'd0, 12'd7, 12'd0);         // same pixel again
    send(CMD_PHOTON, 16'd25, 4'd0, 4'd1, 12'd3, 12'd0);         // channel not in use
    send(CMD_READ, 16'd26, 4'd0, 4'd0, 12'd0, 12'hFFF);
    send(CMD_READ, 16'd27, 4'd0, 4'd0, 12'd0, 12'hFFF);         // cleared by the last read
    send(CMD_READ, 16'd28, 4'd0, 4'd15, 12'd0, 12'hFFF);        // channel outside the store
    send(CMD_MARKER, 16'd40, 4'b0100, 4'd0, 12'd0, 12'd0);
    send(CMD_PHOTON, 16'd41, 4'd0, 4'd0, 12'd9, 12'd0);         // line no longer active
    send(CMD_MARKER, 16'd50, 4'b1000, 4'd0, 12'd0, 12'd0);      // reports the frame count
    send(CMD_MARKER, 16'd60, 4'b1000, 4'd0, 12'd0, 12'd0);      // line time from no line
    send(CMD_ROLLOVER, 16'd0, 4'd0, 4'd0, 12'd0, 12'd0);
    stamp = 100;

    // Random part over a spread of settings, extremes among them.
    phase(1, 0, 4, 4, 4, 2, 0, 0, 1'b0);
    phase(0, 1, 8, 3, 2, 12, 49, 0, 1'b1);
    phase(0, 0, 256, 256, 3, 0, 0, 49, 1'b0);
    phase(1, 1, 1, 1, 1, 15, 11, 11, 1'b0);      // single pixel image
    phase(0, 0, 0, 300, 7, 13, 0, 0, 1'b0);      // width zero and oversized height
    phase(1, 0, 256, 1, 0, 5, 49, 0, 1'b0);      // no channel in use
    phase(0, 1, 511, 2, 4, 12, 0, 49, 1'b0);
    phase(0, 1, 5, 256, 4, 1, 11, 11, 1'b0);

    drain(200);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
